/* rtl/core/inverse_power_and_quotient_table_macros.svh */
// Assertion helpers for the ipqt checker. Both sample on clk and hold off
// while rst_n is low.
`ifndef INVERSE_POWER_AND_QUOTIENT_TABLE_MACROS_SVH
`define INVERSE_POWER_AND_QUOTIENT_TABLE_MACROS_SVH

// same-cycle implication
`define IPQT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipqt check failed");

// next-cycle implication
`define IPQT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipqt check failed");

`endif

/* rtl/core/ipqt_pkg.sv */
package ipqt_pkg;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // program addresses
  localparam pc_t P_IDLE  = 4'd0;
  localparam pc_t P_SQ    = 4'd1;
  localparam pc_t P_SQW   = 4'd2;
  localparam pc_t P_MD    = 4'd3;
  localparam pc_t P_MDW   = 4'd4;
  localparam pc_t P_XUPD  = 4'd5;
  localparam pc_t P_INV   = 4'd6;
  localparam pc_t P_ENT   = 4'd7;
  localparam pc_t P_RIW   = 4'd8;
  localparam pc_t P_RIP   = 4'd9;
  localparam pc_t P_RDW   = 4'd10;
  localparam pc_t P_RDP   = 4'd11;
  localparam pc_t P_DIVW  = 4'd12;
  localparam pc_t P_EMIT  = 4'd13;
  localparam pc_t P_MORE  = 4'd14;
  localparam pc_t P_DONE  = 4'd15;

  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_MUL_XX,
    A_MUL_PD,
    A_X_UPD,
    A_INV_SET,
    A_ENT_START,
    A_RIP_TMP,
    A_RDP_TMP,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_STAY_IDLE,
    C_MUL_BUSY,
    C_DIV_BUSY,
    C_LOOP_MORE,
    C_OUT_FULL,
    C_MORE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic start_ok;
    logic mul_busy;
    logic div_busy;
    logic loop_more;
    logic out_full;
    logic more;
  } status_t;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_DIVISOR   = 1'd0;
  localparam cfg_idx_t REG_WIDE_MODE = 1'd1;

  localparam logic [63:0] NARROW_MASK = 64'h0000_0000_FFFF_FFFF;

  // Control store: jump to target when cond holds, else fall through.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      P_IDLE: w = '{act: A_LOAD,      cond: C_STAY_IDLE, target: P_IDLE};
      P_SQ:   w = '{act: A_MUL_XX,    cond: C_NEXT,      target: P_IDLE};
      P_SQW:  w = '{act: A_NONE,      cond: C_MUL_BUSY,  target: P_SQW};
      P_MD:   w = '{act: A_MUL_PD,    cond: C_NEXT,      target: P_IDLE};
      P_MDW:  w = '{act: A_NONE,      cond: C_MUL_BUSY,  target: P_MDW};
      P_XUPD: w = '{act: A_X_UPD,     cond: C_LOOP_MORE, target: P_SQ};
      P_INV:  w = '{act: A_INV_SET,   cond: C_NEXT,      target: P_IDLE};
      P_ENT:  w = '{act: A_ENT_START, cond: C_NEXT,      target: P_IDLE};
      P_RIW:  w = '{act: A_NONE,      cond: C_MUL_BUSY,  target: P_RIW};
      P_RIP:  w = '{act: A_RIP_TMP,   cond: C_NEXT,      target: P_IDLE};
      P_RDW:  w = '{act: A_NONE,      cond: C_MUL_BUSY,  target: P_RDW};
      P_RDP:  w = '{act: A_RDP_TMP,   cond: C_NEXT,      target: P_IDLE};
      P_DIVW: w = '{act: A_NONE,      cond: C_DIV_BUSY,  target: P_DIVW};
      P_EMIT: w = '{act: A_EMIT,      cond: C_OUT_FULL,  target: P_EMIT};
      P_MORE: w = '{act: A_NONE,      cond: C_MORE,      target: P_ENT};
      P_DONE: w = '{act: A_NONE,      cond: C_ALWAYS,    target: P_IDLE};
      default: w = '{act: A_NONE,     cond: C_ALWAYS,    target: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/ipqt_mul.sv */
// 64x64 -> 128 multiply on one 32x32 multiplier, four partial products.
module ipqt_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         busy,
  output logic [127:0] prod
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic         pp_vld_r;
  logic [2:0]   cnt_r;
  logic         busy_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp_full;
  logic [127:0] pp_ext;
  logic [127:0] pp_shifted;

  always_comb begin
    a_half  = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    b_half  = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp_full = a_half * b_half;
    pp_ext  = {64'd0, pp_r};
    unique case (sh_r)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext << 32;
      2'd2:    pp_shifted = pp_ext << 64;
      default: pp_shifted = pp_ext << 96;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      pp_vld_r <= 1'b0;
    end else if (start) begin
      busy_r   <= 1'b1;
      cnt_r    <= '0;
      pp_vld_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r    <= cnt_r + 3'd1;
      pp_vld_r <= (cnt_r != LAST_STEP);
      busy_r   <= (cnt_r != LAST_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != LAST_STEP) begin
        pp_r <= pp_full;
        sh_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
      end
      if (pp_vld_r) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

/* rtl/core/ipqt_div.sv */
// Restoring divider, one quotient bit per cycle, 64 quotient bits.
module ipqt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quot
);

  logic [63:0] rem_r;
  logic [63:0] q_r;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;

  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, q_r[63]};
    ge     = (rem_sh >= {1'b0, dvs_r});
    diff   = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 6'd1;
      busy_r <= (cnt_r != 6'd63);
    end
  end

  // dividend shifts out of q_r from the top as quotient bits enter below
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : rem_sh[63:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

/* rtl/core/ipqt_seq.sv */
module ipqt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  ipqt_pkg::status_t st,
  output ipqt_pkg::uword_t  uw,
  output ipqt_pkg::pc_t     pc
);

  import ipqt_pkg::*;

  pc_t    pc_r;
  pc_t    pc_nxt;
  uword_t word;
  logic   take;

  always_comb begin
    word = ucode(pc_r);
    unique case (word.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_STAY_IDLE: take = !st.start_ok;
      C_MUL_BUSY:  take = st.mul_busy;
      C_DIV_BUSY:  take = st.div_busy;
      C_LOOP_MORE: take = st.loop_more;
      C_OUT_FULL:  take = st.out_full;
      C_MORE:      take = st.more;
      default:     take = 1'b0;
    endcase
    pc_nxt = take ? word.target : pc_r + pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign uw = word;
  assign pc = pc_r;

endmodule

/* rtl/core/inverse_power_and_quotient_table.sv */
// Throughput: one request at a time. The inverse runs one squaring step per
// iteration (W-1 steps, or 31 in narrow mode, each two multiplies on the shared
// 32x32 unit), then each entry in turn waits on the divider before it is emitted.
// Reset: synchronous, active low; divisor=5, wide_mode=1, sequencer idle,
// output empty. No clearing pass.
module inverse_power_and_quotient_table #(
  parameter int MAX_ENTRIES = 32,
  parameter int WORD_BITS   = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  ipqt_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         in_entry_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_entry_index,
  output logic [63:0]        out_inverse_power,
  output logic [63:0]        out_max_quotient,
  output logic               out_power_overflow,
  output logic               out_not_invertible,
  output logic               out_last_entry
);

  import ipqt_pkg::*;

  localparam int          CW          = $clog2(MAX_ENTRIES + 1);
  localparam int          LW          = $clog2(WORD_BITS);
  localparam int          IW          = (CW > 5) ? CW : 5;
  localparam logic [63:0] WORD_MASK   = {64{1'b1}} >> (64 - WORD_BITS);
  localparam logic [LW-1:0] WIDE_ITER   = LW'(WORD_BITS - 1);
  localparam logic [LW-1:0] NARROW_ITER = LW'(31);
  localparam logic [6:0]  MAX_CNT     = 7'(MAX_ENTRIES);

  // configuration
  logic [63:0] divisor_r;
  logic        wide_r;

  // datapath
  logic [63:0] mask_r;
  logic [63:0] d_r;
  logic        even_r;
  logic [63:0] x_r;
  logic [63:0] inv_r;
  logic [63:0] rip_r;
  logic [63:0] rdp_r;
  logic        ovf_r;
  logic [63:0] rip_tmp_r;
  logic [63:0] rdp_tmp_r;
  logic        ovf_tmp_r;
  logic [LW-1:0] loop_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cnt_r;

  // output word
  logic        out_valid_r;
  logic [4:0]  out_idx_r;
  logic [63:0] out_inv_r;
  logic [63:0] out_q_r;
  logic        out_ovf_r;
  logic        out_even_r;
  logic        out_last_r;

  uword_t  uw;
  pc_t     pc;
  status_t st;
  act_t    act;

  logic         accept_in;
  logic         out_free;
  logic [6:0]   cnt_wide;
  logic [CW-1:0] cnt_clamp;
  logic [63:0]  mask_in;
  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_busy;
  logic [127:0] mul_prod;
  logic         div_start;
  logic         div_busy;
  logic [63:0]  div_quot;
  logic [63:0]  prod_lo;
  logic         prod_ovf;
  logic [CW-1:0] idx_inc;
  logic [IW-1:0] idx_ext;
  logic [63:0]  quot_val;

  assign act       = uw.act;
  assign in_ready  = (pc == P_IDLE);
  assign accept_in = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cnt_wide  = {1'b0, in_entry_count};
    cnt_clamp = (cnt_wide > MAX_CNT) ? CW'(MAX_CNT) : CW'(cnt_wide);
    mask_in   = wide_r ? WORD_MASK : NARROW_MASK;
    prod_lo   = mul_prod[63:0] & mask_r;
    // product beyond the word means the divisor power overflowed
    prod_ovf  = (mul_prod[127:64] != 64'd0) || ((mul_prod[63:0] & ~mask_r) != 64'd0);
    idx_inc   = idx_r + CW'(1);
    idx_ext   = IW'(idx_r);
    quot_val  = (ovf_r || rdp_r == 64'd0) ? 64'd0 : div_quot;

    st.start_ok  = in_valid && (cnt_clamp != '0);
    st.mul_busy  = mul_busy;
    st.div_busy  = div_busy;
    st.loop_more = (loop_r != LW'(1));
    st.out_full  = !out_free;
    st.more      = (idx_r != cnt_r);

    mul_start = 1'b1;
    unique case (act)
      A_MUL_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      A_MUL_PD: begin
        mul_a = prod_lo;
        mul_b = d_r;
      end
      A_ENT_START: begin
        mul_a = rip_r;
        mul_b = inv_r;
      end
      A_RIP_TMP: begin
        mul_a = rdp_r;
        mul_b = d_r;
      end
      default: begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
      end
    endcase
    div_start = (act == A_ENT_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= 64'd5;
      wide_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIVISOR:   divisor_r <= cfg_wdata;
        REG_WIDE_MODE: wide_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // an emit step reloads the output word itself
      if (out_valid_r && out_ready && act != A_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (act)
        A_LOAD: begin
          if (accept_in) begin
            loop_r <= wide_r ? WIDE_ITER : NARROW_ITER;
            idx_r  <= '0;
            cnt_r  <= cnt_clamp;
          end
        end
        A_X_UPD: loop_r <= loop_r - LW'(1);
        A_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            idx_r       <= idx_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (act)
      A_LOAD: begin
        if (accept_in) begin
          mask_r <= mask_in;
          d_r    <= divisor_r & mask_in;
          even_r <= ~divisor_r[0];
          x_r    <= 64'd1;
          rip_r  <= 64'd1;
          rdp_r  <= 64'd1;
          ovf_r  <= 1'b0;
        end
      end
      A_X_UPD:   x_r       <= prod_lo;
      A_INV_SET: inv_r     <= x_r;
      A_RIP_TMP: rip_tmp_r <= prod_lo;
      A_RDP_TMP: begin
        if (ovf_r || prod_ovf) begin
          rdp_tmp_r <= rdp_r;
          ovf_tmp_r <= 1'b1;
        end else if (d_r == 64'd0) begin
          rdp_tmp_r <= 64'd0;
          ovf_tmp_r <= 1'b1;
        end else begin
          rdp_tmp_r <= mul_prod[63:0];
          ovf_tmp_r <= 1'b0;
        end
      end
      A_EMIT: begin
        if (out_free) begin
          out_idx_r  <= idx_ext[4:0];
          out_inv_r  <= even_r ? 64'd0 : rip_r;
          out_q_r    <= quot_val;
          out_ovf_r  <= ovf_r;
          out_even_r <= even_r;
          out_last_r <= (idx_inc == cnt_r);
          rip_r      <= rip_tmp_r;
          rdp_r      <= rdp_tmp_r;
          ovf_r      <= ovf_tmp_r;
        end
      end
      default: begin
      end
    endcase
  end

  ipqt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw),
    .pc    (pc)
  );

  ipqt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  ipqt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mask_r),
    .divisor  (rdp_r),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  assign out_valid          = out_valid_r;
  assign out_entry_index    = out_idx_r;
  assign out_inverse_power  = out_inv_r;
  assign out_max_quotient   = out_q_r;
  assign out_power_overflow = out_ovf_r;
  assign out_not_invertible = out_even_r;
  assign out_last_entry     = out_last_r;

endmodule

/* rtl/core/ipqt_checker.sv */
`include "inverse_power_and_quotient_table_macros.svh"

module ipqt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [5:0]  in_entry_count,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_entry_index,
  input logic [63:0] out_inverse_power,
  input logic [63:0] out_max_quotient,
  input logic        out_power_overflow,
  input logic        out_not_invertible
);

  // an accepted request with entries closes the input
  `IPQT_ASSERT_NEXT(a_busy_after_start, in_valid && in_ready && in_entry_count != 6'd0, !in_ready)

  `IPQT_ASSERT_NOW(a_even_zero_inv, out_valid && out_not_invertible, out_inverse_power == 64'd0)

  `IPQT_ASSERT_NOW(a_ovf_zero_quot, out_valid && out_power_overflow, out_max_quotient == 64'd0)

  `IPQT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_max_quotient) && $stable(out_inverse_power) && $stable(out_entry_index))

endmodule

bind inverse_power_and_quotient_table ipqt_checker u_ipqt_checker (.*);
